[design/rssp_pkg.sv]
`timescale 1ns / 1ps

package rssp_pkg;

  localparam int NUM_SLOTS_DEF   = 4;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int KIND_W       = 2;
  localparam int SLOT_FIELD_W = 6;
  localparam int STATUS_W     = 3;

  localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSTALL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage

[design/rssp_free_stack.sv]
`timescale 1ns / 1ps

module rssp_free_stack
  import rssp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SLOT_W    = $clog2(NUM_SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] top_addr,
  input  logic              push_en,
  input  logic [SLOT_W-1:0] push_slot,
  output logic [SLOT_W-1:0] top_slot
);

  logic [SLOT_W-1:0]    mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_r;
  logic [SLOT_W-1:0]    rd_q;
  logic                 rd_vld_r;
  logic [SLOT_W-1:0]    rd_addr_r;
  logic                 byp_r;
  logic [SLOT_W-1:0]    byp_slot_r;

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[top_addr] <= push_slot;
    end
    rd_q       <= mem[top_addr];
    byp_slot_r <= push_slot;
  end

  // An entry that was never written still holds its reset value, slot index plus one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_addr_r <= SLOT_W'(NUM_SLOTS - 2);
      byp_r     <= 1'b0;
    end else begin
      if (push_en) begin
        vld_r[top_addr] <= 1'b1;
      end
      rd_vld_r  <= vld_r[top_addr];
      rd_addr_r <= top_addr;
      byp_r     <= push_en;
    end
  end

  assign top_slot = byp_r    ? byp_slot_r :
                    rd_vld_r ? rd_q       : rd_addr_r + 1'b1;

endmodule

[design/refcounted_snapshot_slot_pool_core.sv]
`timescale 1ns / 1ps

// Snapshot slot pool with reader counts: acquire pins the current slot, release unpins a
// slot and returns it to a LIFO free stack when it drops to zero while not current, and
// install pops a free slot, makes it current with one pin and unpins the old current slot.
// One operation is accepted every cycle while the result is not stalled; it passes
// through an input register, then one pass of counter and stack logic into the result
// register. The reader counts of non-current slots and the free stack are memories with
// registered reads that are fetched while the operation before is processed, with
// forwarding from the operation in progress; per-entry valid bits stand in for their
// reset values, so no clearing pass is needed and operations are taken once reset ends.
module refcounted_snapshot_slot_pool_core
  import rssp_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [SLOT_FIELD_W-1:0] in_slot,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SLOT_FIELD_W-1:0] out_granted_slot,
  output logic [STATUS_W-1:0]     out_status,
  output logic                    out_freed_valid,
  output logic [SLOT_FIELD_W-1:0] out_freed_slot
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [COUNT_WIDTH-1:0]  CNT_MAX     = '1;
  localparam logic [SLOT_FIELD_W:0]   NUM_SLOTS_V = (SLOT_FIELD_W + 1)'(NUM_SLOTS);

  logic en;
  logic in_accept;

  logic                    v1_r;
  logic [KIND_W-1:0]       kind1_r;
  logic [SLOT_FIELD_W-1:0] slot1_r;

  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [COUNT_WIDTH-1:0] cur_cnt_r, cur_cnt_nxt;
  logic [SLOT_W-1:0]      fc_r, fc_nxt;

  logic [COUNT_WIDTH-1:0] cnt_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   cnt_vld_r;
  logic [COUNT_WIDTH-1:0] cnt_q;
  logic                   cnt_rd_vld_r;
  logic                   cnt_byp_r;
  logic [COUNT_WIDTH-1:0] cnt_byp_data_r;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [SLOT_W-1:0]      in_idx;

  logic                   cw_en;
  logic [SLOT_W-1:0]      cw_addr;
  logic [COUNT_WIDTH-1:0] cw_data;

  logic              push_en;
  logic [SLOT_W-1:0] push_slot;
  logic [SLOT_W-1:0] top_addr;
  logic [SLOT_W-1:0] top_slot;

  logic [SLOT_W-1:0]      idx1;
  logic [COUNT_WIDTH-1:0] held;
  logic [COUNT_WIDTH-1:0] dec;

  logic [SLOT_FIELD_W-1:0] res_granted;
  logic [STATUS_W-1:0]     res_status;
  logic                    res_fv;
  logic [SLOT_FIELD_W-1:0] res_fs;

  logic                    out_valid_r;
  logic [SLOT_FIELD_W-1:0] out_granted_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic                    out_fv_r;
  logic [SLOT_FIELD_W-1:0] out_fs_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign in_accept = in_valid && en;
  assign in_idx    = in_slot[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind1_r <= in_kind;
      slot1_r <= in_slot;
    end
  end

  // Reader counts of slots that are not current; the current count lives in cur_cnt_r.
  always_ff @(posedge clk) begin
    if (cw_en) begin
      cnt_mem[cw_addr] <= cw_data;
    end
    if (in_accept) begin
      cnt_q          <= cnt_mem[in_idx];
      cnt_byp_data_r <= cw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r    <= '0;
      cnt_rd_vld_r <= 1'b0;
      cnt_byp_r    <= 1'b0;
    end else begin
      if (cw_en) begin
        cnt_vld_r[cw_addr] <= 1'b1;
      end
      if (in_accept) begin
        cnt_rd_vld_r <= cnt_vld_r[in_idx];
        cnt_byp_r    <= cw_en && (cw_addr == in_idx);
      end
    end
  end

  assign cnt_rd = cnt_byp_r    ? cnt_byp_data_r :
                  cnt_rd_vld_r ? cnt_q          : '0;

  assign idx1 = slot1_r[SLOT_W-1:0];
  assign held = (idx1 == cur_r) ? cur_cnt_r : cnt_rd;
  assign dec  = held - 1'b1;

  always_comb begin
    cur_nxt     = cur_r;
    cur_cnt_nxt = cur_cnt_r;
    fc_nxt      = fc_r;
    cw_en       = 1'b0;
    cw_addr     = cur_r;
    cw_data     = '0;
    push_en     = 1'b0;
    push_slot   = cur_r;
    res_granted = '0;
    res_status  = ST_OK;
    res_fv      = 1'b0;
    res_fs      = '0;
    if (v1_r && en) begin
      case (kind1_r)
        KIND_ACQUIRE: begin
          if (cur_cnt_r == CNT_MAX) begin
            res_status = ST_FULL;
          end else begin
            cur_cnt_nxt = cur_cnt_r + 1'b1;
            res_granted = SLOT_FIELD_W'(cur_r);
          end
        end
        KIND_RELEASE: begin
          if ({1'b0, slot1_r} >= NUM_SLOTS_V) begin
            res_status = ST_INVALID;
          end else if (held == '0) begin
            res_status = ST_NOT_HELD;
          end else if (idx1 == cur_r) begin
            cur_cnt_nxt = dec;
          end else begin
            cw_en   = 1'b1;
            cw_addr = idx1;
            cw_data = dec;
            if (dec == '0) begin
              push_en   = 1'b1;
              push_slot = idx1;
              fc_nxt    = fc_r + 1'b1;
              res_fv    = 1'b1;
              res_fs    = SLOT_FIELD_W'(idx1);
            end
          end
        end
        KIND_INSTALL: begin
          if (fc_r == '0) begin
            res_status = ST_EXHAUSTED;
          end else begin
            cur_nxt     = top_slot;
            cur_cnt_nxt = COUNT_WIDTH'(1);
            res_granted = SLOT_FIELD_W'(top_slot);
            cw_en       = 1'b1;
            cw_addr     = cur_r;
            cw_data     = (cur_cnt_r == '0) ? '0 : cur_cnt_r - 1'b1;
            if (cur_cnt_r <= COUNT_WIDTH'(1)) begin
              push_en   = 1'b1;
              push_slot = cur_r;
              fc_nxt    = fc_r;
              res_fv    = 1'b1;
              res_fs    = SLOT_FIELD_W'(cur_r);
            end else begin
              fc_nxt = fc_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign top_addr = fc_nxt - 1'b1;

  rssp_free_stack #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .top_addr  (top_addr),
    .push_en   (push_en),
    .push_slot (push_slot),
    .top_slot  (top_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      cur_cnt_r <= COUNT_WIDTH'(1);
      fc_r      <= SLOT_W'(NUM_SLOTS - 1);
    end else begin
      cur_r     <= cur_nxt;
      cur_cnt_r <= cur_cnt_nxt;
      fc_r      <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_granted_r <= res_granted;
      out_status_r  <= res_status;
      out_fv_r      <= res_fv;
      out_fs_r      <= res_fs;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_granted_r;
  assign out_status       = out_status_r;
  assign out_freed_valid  = out_fv_r;
  assign out_freed_slot   = out_fs_r;

endmodule

[design/rssp_checker.sv]
`timescale 1ns / 1ps

module rssp_checker
  import rssp_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SLOT_FIELD_W-1:0] out_granted_slot,
  input logic [STATUS_W-1:0]     out_status,
  input logic                    out_freed_valid,
  input logic [SLOT_FIELD_W-1:0] out_freed_slot
);

  localparam logic [SLOT_FIELD_W:0] NUM_SLOTS_V = (SLOT_FIELD_W + 1)'(NUM_SLOTS);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_slot) &&
      $stable(out_status) && $stable(out_freed_valid) && $stable(out_freed_slot))
    else $error("result changed while stalled");

  // A slot is freed only by an operation that succeeded.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_freed_valid |-> out_status == ST_OK)
    else $error("slot freed by a failed operation");

  // Failed operations grant nothing and free nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EXHAUSTED || out_status == ST_INVALID ||
      out_status == ST_NOT_HELD || out_status == ST_FULL)
    |-> out_granted_slot == '0 && !out_freed_valid)
    else $error("failed operation granted or freed a slot");

  // Freed and granted indices stay inside the pool; no freed index without a free.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_granted_slot} < NUM_SLOTS_V &&
      (out_freed_valid ? {1'b0, out_freed_slot} < NUM_SLOTS_V : out_freed_slot == '0))
    else $error("slot index outside the pool");

endmodule

bind refcounted_snapshot_slot_pool_core rssp_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_rssp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_granted_slot (out_granted_slot),
  .out_status       (out_status),
  .out_freed_valid  (out_freed_valid),
  .out_freed_slot   (out_freed_slot)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import rssp_pkg::*;

  localparam int NUM_SLOTS   = NUM_SLOTS_DEF;
  localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic [STATUS_W-1:0]     status;
    logic                    freed_valid;
    logic [SLOT_FIELD_W-1:0] freed_slot;
  } pool_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [KIND_W-1:0]       in_kind = '0;
  logic [SLOT_FIELD_W-1:0] in_slot = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [SLOT_FIELD_W-1:0] out_granted_slot;
  logic [STATUS_W-1:0]     out_status;
  logic                    out_freed_valid;
  logic [SLOT_FIELD_W-1:0] out_freed_slot;

  // Shadow copy of the pool state, advanced at each accepted input transfer.
  int                      live_slot;
  logic [COUNT_WIDTH-1:0]  pins [NUM_SLOTS];
  bit                      in_use [NUM_SLOTS];
  int                      free_lifo [NUM_SLOTS];
  int                      free_depth;

  pool_result_t            pending_results [$];
  int                      mismatch_count = 0;
  bit                      idle_on = 1'b1;
  bit                      result_taken = 1'b0;

  refcounted_snapshot_slot_pool_core #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted_slot(out_granted_slot),
    .out_status      (out_status),
    .out_freed_valid (out_freed_valid),
    .out_freed_slot  (out_freed_slot)
  );

  always #1 clk = ~clk;

  function automatic void reset_pool();
    live_slot = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pins[i] = '0;
      in_use[i] = 1'b0;
      free_lifo[i] = 0;
    end
    pins[0] = 1;
    in_use[0] = 1'b1;
    for (int i = 1; i < NUM_SLOTS; i++) free_lifo[i-1] = i;
    free_depth = NUM_SLOTS - 1;
  endfunction

  function automatic void return_to_pool(int s, inout pool_result_t r);
    in_use[s] = 1'b0;
    pins[s] = '0;
    if (free_depth < NUM_SLOTS) begin
      free_lifo[free_depth] = s;
      free_depth++;
    end
    r.freed_valid = 1'b1;
    r.freed_slot = SLOT_FIELD_W'(s);
  endfunction

  function automatic logic [STATUS_W-1:0] drop_pin(int s, inout pool_result_t r);
    if (pins[s] == 0) return ST_NOT_HELD;
    pins[s] = pins[s] - 1'b1;
    if (pins[s] == 0 && s != live_slot && in_use[s]) return_to_pool(s, r);
    return ST_OK;
  endfunction

  function automatic pool_result_t compute_pool_op(logic [KIND_W-1:0] k,
                                                   logic [SLOT_FIELD_W-1:0] s);
    pool_result_t r;
    int old_s;
    int new_s;
    r = '0;
    case (k)
      KIND_ACQUIRE: begin
        if (pins[live_slot] == COUNT_MAX) begin
          r.status = ST_FULL;
        end else begin
          pins[live_slot] = pins[live_slot] + 1'b1;
          r.granted_slot = SLOT_FIELD_W'(live_slot);
        end
      end
      KIND_RELEASE: begin
        if (s >= NUM_SLOTS) r.status = ST_INVALID;
        else r.status = drop_pin(int'(s), r);
      end
      KIND_INSTALL: begin
        if (free_depth == 0) begin
          r.status = ST_EXHAUSTED;
        end else begin
          old_s = live_slot;
          free_depth--;
          new_s = free_lifo[free_depth];
          pins[new_s] = 1;
          in_use[new_s] = 1'b1;
          live_slot = new_s;
          r.granted_slot = SLOT_FIELD_W'(new_s);
          // An old slot with no pin left has nothing holding it and goes back at once.
          if (pins[old_s] == 0) begin
            if (in_use[old_s] && old_s != new_s) return_to_pool(old_s, r);
          end else begin
            void'(drop_pin(old_s, r));
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_FIELD_W-1:0] any_slot();
    return SLOT_FIELD_W'($urandom_range(0, 63));
  endfunction

  // Returns a random slot whose pinned state matches, or -1 when there is none.
  function automatic int pick_slot(bit held, bit skip_live);
    int cands [$];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (((pins[i] != 0) == held) && !(skip_live && i == live_slot)) begin
        cands.insert(cands.size(), i);
      end
    end
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] k, input logic [SLOT_FIELD_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_slot <= s;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), compute_pool_op(k, s));
  endtask

  task automatic test_directed();
    int h;
    idle_on = 1'b1;
    send_op(KIND_ACQUIRE, 6'd0);
    send_op(KIND_RELEASE, 6'd0);
    send_op(KIND_RELEASE, 6'd0);
    send_op(KIND_RELEASE, 6'd0);
    send_op(KIND_ACQUIRE, 6'd63);
    send_op(KIND_RELEASE, 6'd63);
    send_op(KIND_RELEASE, SLOT_FIELD_W'(NUM_SLOTS));
    send_op(KIND_UNUSED, 6'h2A);
    send_op(KIND_UNUSED, 6'h15);
    send_op(KIND_RELEASE, 6'd1);
    send_op(KIND_RELEASE, SLOT_FIELD_W'(live_slot));
    send_op(KIND_INSTALL, 6'd0);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_op(KIND_ACQUIRE, any_slot());
      send_op(KIND_INSTALL, any_slot());
    end
    for (int i = 0; i < NUM_SLOTS - 1; i++) begin
      h = pick_slot(1'b1, 1'b1);
      if (h >= 0) send_op(KIND_RELEASE, SLOT_FIELD_W'(h));
    end
  endtask

  task automatic test_random_ops(input int chunks, input int per_chunk);
    int r;
    int h;
    for (int c = 0; c < chunks; c++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < per_chunk; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          send_op(KIND_ACQUIRE, any_slot());
        end else if (r < 65) begin
          h = pick_slot(1'b1, 1'b0);
          if (h < 0) h = $urandom_range(0, NUM_SLOTS - 1);
          send_op(KIND_RELEASE, SLOT_FIELD_W'(h));
        end else if (r < 82) begin
          send_op(KIND_INSTALL, any_slot());
        end else if (r < 90) begin
          send_op(KIND_RELEASE, any_slot());
        end else if (r < 95) begin
          h = pick_slot(1'b0, 1'b0);
          if (h < 0) h = $urandom_range(0, NUM_SLOTS - 1);
          send_op(KIND_RELEASE, SLOT_FIELD_W'(h));
        end else begin
          send_op(KIND_UNUSED, any_slot());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_taken = 1'b1;
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want.granted_slot, out_granted_slot);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_freed_valid !== want.freed_valid) begin
          $error("freed_valid: expected %0d, got %0d", want.freed_valid, out_freed_valid);
          mismatch_count++;
        end
        if (out_freed_slot !== want.freed_slot) begin
          $error("freed_slot: expected %0d, got %0d", want.freed_slot, out_freed_slot);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (result_taken) begin
        hold = idle_on ? $urandom_range(0, 11) : 0;
        result_taken = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    reset_pool();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_ops(9, 150);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
design/rssp_pkg.sv
design/rssp_free_stack.sv
design/refcounted_snapshot_slot_pool_core.sv
design/rssp_checker.sv
tb/sv/testbench.sv
